// ===== hw/rtl/tpdi_pkg.sv =====
// Package for the triangle pixel depth interpolator: beat types and widths.
// No dependencies.
`timescale 1ns / 1ps
package tpdi_pkg;
    localparam int COORD_BITS      = 16;
    localparam int DEPTH_FRAC_BITS = 16;
    localparam int FIELD_W         = 16;
    localparam int DEPTH_BITS      = 32;
    localparam int DIFF_W          = COORD_BITS + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int CROSS_W         = PROD_W + 1;
    localparam int WGT_W           = CROSS_W - 1;
    localparam int TOT_W           = WGT_W + 2;
    localparam int WPRD_W          = WGT_W + 1 + DEPTH_BITS;
    localparam int NUM_W           = WPRD_W + 1;
    localparam int QUO_W           = DEPTH_BITS;
    localparam int REM_W           = TOT_W;

    typedef struct packed {
        logic signed [FIELD_W-1:0]    pixel_x;
        logic signed [FIELD_W-1:0]    pixel_y;
        logic signed [FIELD_W-1:0]    vertex_a_x;
        logic signed [FIELD_W-1:0]    vertex_a_y;
        logic signed [DEPTH_BITS-1:0] vertex_a_depth;
        logic signed [FIELD_W-1:0]    vertex_b_x;
        logic signed [FIELD_W-1:0]    vertex_b_y;
        logic signed [DEPTH_BITS-1:0] vertex_b_depth;
        logic signed [FIELD_W-1:0]    vertex_c_x;
        logic signed [FIELD_W-1:0]    vertex_c_y;
        logic signed [DEPTH_BITS-1:0] vertex_c_depth;
    } tpdi_in_t;

    typedef struct packed {
        logic signed [DEPTH_BITS-1:0] pixel_depth;
        logic                         degenerate;
    } tpdi_out_t;

    typedef struct packed {
        logic neg;
        logic degen;
    } tpdi_meta_t;
endpackage

// ===== hw/rtl/tpdi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with stall enable.
// Depends on tpdi_pkg.
`timescale 1ns / 1ps
module tpdi_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  tpdi_pkg::tpdi_meta_t        in_meta,
    input  logic [tpdi_pkg::REM_W-1:0]  in_rem,
    input  logic [tpdi_pkg::QUO_W-1:0]  in_low,
    input  logic [tpdi_pkg::TOT_W-1:0]  in_den,
    output logic                        out_valid,
    output tpdi_pkg::tpdi_meta_t        out_meta,
    output logic [tpdi_pkg::QUO_W-1:0]  out_quo
);
    import tpdi_pkg::*;

    logic                vld_reg  [QUO_W];
    tpdi_meta_t          meta_reg [QUO_W];
    logic [REM_W-1:0]    rem_reg  [QUO_W];
    logic [QUO_W-1:0]    low_reg  [QUO_W];
    logic [QUO_W-1:0]    quo_reg  [QUO_W];
    logic [TOT_W-1:0]    den_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic             vld_prev;
        tpdi_meta_t       meta_prev;
        logic [REM_W-1:0] rem_prev;
        logic [QUO_W-1:0] low_prev;
        logic [QUO_W-1:0] quo_prev;
        logic [TOT_W-1:0] den_prev;
        logic [REM_W:0]   trial;
        logic             ge;
        logic [REM_W:0]   diff;

        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign meta_prev = in_meta;
            assign rem_prev  = in_rem;
            assign low_prev  = in_low;
            assign quo_prev  = '0;
            assign den_prev  = in_den;
        end else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign meta_prev = meta_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign low_prev  = low_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign den_prev  = den_reg[k-1];
        end

        assign trial = {rem_prev, low_prev[QUO_W-1]};
        assign ge    = trial >= {1'b0, den_prev};
        assign diff  = trial - {1'b0, den_prev};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                meta_reg[k] <= meta_prev;
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                low_reg[k]  <= {low_prev[QUO_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_prev[QUO_W-2:0], ge};
                den_reg[k]  <= den_prev;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_meta  = meta_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
endmodule

// ===== hw/rtl/triangle_pixel_depth_interpolator.sv =====
// Top level: barycentric depth interpolation of one pixel in one triangle per beat.
// Depends on tpdi_pkg and tpdi_div.
`timescale 1ns / 1ps
//  channel | ports                       | beat
//  input   | s_valid, s_ready, s_data    | pixel plus three vertices
//  result  | m_valid, m_ready, m_data    | depth and degenerate flag
//
//  One beat per cycle sustained while results are taken; six arithmetic stages,
//  32 divider stages (one quotient bit each), one output register.
//  The whole pipeline holds while the output register is full and not taken.
//  Reset clears all valid bits; payload registers are not reset.
module triangle_pixel_depth_interpolator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tpdi_pkg::tpdi_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tpdi_pkg::tpdi_out_t   m_data
);
    import tpdi_pkg::*;

    logic m_valid_reg;
    tpdi_out_t m_data_reg;

    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // stage 1: offsets from pixel
    logic v1_reg;
    logic signed [DIFF_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [DEPTH_BITS-1:0] da1_reg, db1_reg, dc1_reg;

    function automatic logic signed [DIFF_W-1:0] offs(input logic [FIELD_W-1:0] v,
                                                      input logic [FIELD_W-1:0] p);
        logic signed [DIFF_W-1:0] ve;
        logic signed [DIFF_W-1:0] pe;
        ve = DIFF_W'($signed(v[COORD_BITS-1:0]));
        pe = DIFF_W'($signed(p[COORD_BITS-1:0]));
        return ve - pe;
    endfunction

    // stage 2: products
    logic v2_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DEPTH_BITS-1:0] da2_reg, db2_reg, dc2_reg;

    // stage 3: weights
    logic v3_reg;
    logic [WGT_W-1:0] wa_reg, wb_reg, wc_reg;
    logic [TOT_W-1:0] tot3_reg;
    logic signed [DEPTH_BITS-1:0] da3_reg, db3_reg, dc3_reg;

    function automatic logic [WGT_W-1:0] abs_cross(input logic signed [PROD_W-1:0] x,
                                                   input logic signed [PROD_W-1:0] y);
        logic signed [CROSS_W-1:0] c;
        logic signed [CROSS_W-1:0] m;
        c = CROSS_W'(x) - CROSS_W'(y);
        m = c[CROSS_W-1] ? -c : c;
        return m[WGT_W-1:0];
    endfunction

    // stage 4: weighted depths
    logic v4_reg;
    logic signed [WPRD_W-1:0] qa_reg, qb_reg, qc_reg;
    logic [TOT_W-1:0] tot4_reg;

    // stage 5: numerator
    logic v5_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [TOT_W-1:0] tot5_reg;
    logic degen5_reg;

    // stage 6: magnitude
    logic v6_reg;
    logic [NUM_W-1:0] mag_reg;
    logic [TOT_W-1:0] tot6_reg;
    tpdi_meta_t meta6_reg;
    logic signed [NUM_W-1:0] mag_next;

    assign mag_next = num_reg[NUM_W-1] ? -num_reg : num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg  <= offs(s_data.vertex_a_x, s_data.pixel_x);
            ay_reg  <= offs(s_data.vertex_a_y, s_data.pixel_y);
            bx_reg  <= offs(s_data.vertex_b_x, s_data.pixel_x);
            by_reg  <= offs(s_data.vertex_b_y, s_data.pixel_y);
            cx_reg  <= offs(s_data.vertex_c_x, s_data.pixel_x);
            cy_reg  <= offs(s_data.vertex_c_y, s_data.pixel_y);
            da1_reg <= s_data.vertex_a_depth;
            db1_reg <= s_data.vertex_b_depth;
            dc1_reg <= s_data.vertex_c_depth;

            p0_reg  <= PROD_W'(bx_reg) * PROD_W'(cy_reg);
            p1_reg  <= PROD_W'(by_reg) * PROD_W'(cx_reg);
            p2_reg  <= PROD_W'(ax_reg) * PROD_W'(cy_reg);
            p3_reg  <= PROD_W'(ay_reg) * PROD_W'(cx_reg);
            p4_reg  <= PROD_W'(ax_reg) * PROD_W'(by_reg);
            p5_reg  <= PROD_W'(ay_reg) * PROD_W'(bx_reg);
            da2_reg <= da1_reg;
            db2_reg <= db1_reg;
            dc2_reg <= dc1_reg;

            wa_reg   <= abs_cross(p0_reg, p1_reg);
            wb_reg   <= abs_cross(p2_reg, p3_reg);
            wc_reg   <= abs_cross(p4_reg, p5_reg);
            tot3_reg <= TOT_W'(abs_cross(p0_reg, p1_reg))
                      + TOT_W'(abs_cross(p2_reg, p3_reg))
                      + TOT_W'(abs_cross(p4_reg, p5_reg));
            da3_reg  <= da2_reg;
            db3_reg  <= db2_reg;
            dc3_reg  <= dc2_reg;

            qa_reg   <= $signed({1'b0, wa_reg}) * da3_reg;
            qb_reg   <= $signed({1'b0, wb_reg}) * db3_reg;
            qc_reg   <= $signed({1'b0, wc_reg}) * dc3_reg;
            tot4_reg <= tot3_reg;

            num_reg    <= NUM_W'(qa_reg) + NUM_W'(qb_reg) + NUM_W'(qc_reg);
            tot5_reg   <= tot4_reg;
            degen5_reg <= tot4_reg == '0;

            mag_reg         <= mag_next;
            tot6_reg        <= tot5_reg;
            meta6_reg.neg   <= num_reg[NUM_W-1];
            meta6_reg.degen <= degen5_reg;
        end
    end

    logic                 dv_valid;
    tpdi_meta_t           dv_meta;
    logic [QUO_W-1:0]     dv_quo;

    tpdi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v6_reg),
        .in_meta   (meta6_reg),
        .in_rem    (mag_reg[REM_W+QUO_W-1:QUO_W]),
        .in_low    (mag_reg[QUO_W-1:0]),
        .in_den    (tot6_reg),
        .out_valid (dv_valid),
        .out_meta  (dv_meta),
        .out_quo   (dv_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.degenerate <= dv_meta.degen;
            if (dv_meta.degen) begin
                m_data_reg.pixel_depth <= '0;
            end else if (dv_meta.neg) begin
                m_data_reg.pixel_depth <= -$signed(dv_quo);
            end else begin
                m_data_reg.pixel_depth <= $signed(dv_quo);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
